[rtl/wmsr_pkg.sv]
// Shared constants and controller/datapath interface types for the median core.
package wmsr_pkg;
   localparam int MAX_WINDOW  = 256;
   localparam int PRICE_BITS  = 31;
   localparam int IDX_BITS    = $clog2(MAX_WINDOW);
   localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
   localparam int BARS_BITS   = 10;
   localparam int SQ_BITS     = 2 * PRICE_BITS;
   localparam int MED_BITS    = 63;
   localparam int WIN_BITS    = 8;
   localparam int USED_BITS   = 9;
   localparam logic [WIN_BITS-1:0]  WINDOW_RESET = WIN_BITS'(180);
   localparam logic [BARS_BITS-1:0] BARS_CAP =
      BARS_BITS'((MAX_WINDOW + 2) > 1023 ? (MAX_WINDOW + 2) : 1023);
   localparam logic [CNT_BITS-1:0]  MIN_USED = CNT_BITS'(3);

   typedef struct packed {
      logic accept;
      logic square;
      logic scan_start;
      logic cand_rd;
      logic cand_cap;
      logic sweep;
      logic eval;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic few_returns;
      logic sweep_done;
      logic scan_last;
      logic out_blocked;
   } sts_type;
endpackage

[rtl/wmsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wmsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/wmsr_ctrl.sv]
// Sequencer for the square, store and rank-selection passes.
module wmsr_ctrl
   import wmsr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    idle,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SQ    = 8'b0000_0010,
      S_CHK   = 8'b0000_0100,
      S_CAND  = 8'b0000_1000,
      S_LAT   = 8'b0001_0000,
      S_SWEEP = 8'b0010_0000,
      S_EVAL  = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SQ;
            end
         end
         S_SQ: begin
            cmd.square = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (sts.few_returns) begin
               state_in = S_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_CAND;
            end
         end
         S_CAND: begin
            cmd.cand_rd = 1'b1;
            state_in    = S_LAT;
         end
         S_LAT: begin
            cmd.cand_cap = 1'b1;
            state_in     = S_SWEEP;
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.scan_last ? S_OUT : S_CAND;
         end
         S_OUT: begin
            // hold until the output register frees up
            if (!sts.out_blocked) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == S_IDLE);
endmodule

[rtl/wmsr_dp.sv]
// Datapath: squared returns, ring storage, rank counting and output register.
module wmsr_dp
   import wmsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic                  csr_valid,
   input  logic [WIN_BITS-1:0]   csr_window_bars,
   input  logic [PRICE_BITS-1:0] req_close_price,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MED_BITS-1:0]   rsp_median_x2,
   output logic [USED_BITS-1:0]  rsp_used_count
);
   logic [PRICE_BITS-1:0] prev_ff;
   logic [BARS_BITS-1:0]  bars_ff;
   logic [IDX_BITS-1:0]   wp_ff;
   logic [WIN_BITS-1:0]   win_ff;
   logic                  rsp_valid_ff;
   logic                  pv_ff;

   logic [PRICE_BITS-1:0] d_ff;
   logic                  store_ff;
   logic [CNT_BITS-1:0]   used_ff, i_ff, j_ff, lt_ff, le_ff;
   logic [SQ_BITS-1:0]    cand_ff, lo_ff, hi_ff;
   logic [MED_BITS-1:0]   med_ff;
   logic [USED_BITS-1:0]  cnt_ff;

   logic [PRICE_BITS-1:0] diff;
   logic [SQ_BITS-1:0]    sq, rd_data;
   logic [IDX_BITS-1:0]   rd_addr, ofs;
   logic [CNT_BITS-1:0]   stored, wlen, used_in, k_lo, k_hi;
   logic [BARS_BITS-1:0]  stored_raw;
   logic                  issue;

   assign diff = (req_close_price >= prev_ff) ? req_close_price - prev_ff
                                              : prev_ff - req_close_price;
   assign sq   = SQ_BITS'({{PRICE_BITS{1'b0}}, d_ff} * {{PRICE_BITS{1'b0}}, d_ff});

   assign stored_raw = (bars_ff >= BARS_BITS'(2)) ? bars_ff - BARS_BITS'(2) : '0;
   assign stored     = (stored_raw > BARS_BITS'(MAX_WINDOW)) ? CNT_BITS'(MAX_WINDOW)
                                                            : CNT_BITS'(stored_raw);
   assign wlen       = (CNT_BITS'(win_ff) > CNT_BITS'(MAX_WINDOW - 1))
                       ? CNT_BITS'(MAX_WINDOW) : CNT_BITS'(win_ff) + CNT_BITS'(1);
   assign used_in    = (wlen < stored) ? wlen : stored;

   assign ofs     = cmd.cand_rd ? i_ff[IDX_BITS-1:0] : j_ff[IDX_BITS-1:0];
   assign rd_addr = wp_ff - IDX_BITS'(1) - ofs;
   assign issue   = cmd.sweep && (j_ff < used_ff);

   assign k_lo = (used_ff - CNT_BITS'(1)) >> 1;
   assign k_hi = used_ff >> 1;

   wmsr_ram #(.WIDTH(SQ_BITS), .DEPTH(MAX_WINDOW)) u_ring (
      .clock   (clock),
      .wr_en   (cmd.square && store_ff),
      .wr_addr (wp_ff),
      .wr_data (sq),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         bars_ff      <= '0;
         wp_ff        <= '0;
         win_ff       <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         if (csr_valid) begin
            win_ff <= csr_window_bars;
         end
         if (cmd.accept) begin
            prev_ff <= req_close_price;
            if (bars_ff < BARS_CAP) begin
               bars_ff <= bars_ff + BARS_BITS'(1);
            end
         end
         if (cmd.square && store_ff) begin
            wp_ff <= wp_ff + IDX_BITS'(1);
         end
         pv_ff <= issue;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         d_ff     <= diff;
         store_ff <= (bars_ff >= BARS_BITS'(2));
      end
      if (cmd.square) begin
         used_ff <= used_in;
      end
      if (cmd.scan_start) begin
         i_ff <= '0;
      end
      if (cmd.cand_cap) begin
         cand_ff <= rd_data;
         j_ff    <= '0;
         lt_ff   <= '0;
         le_ff   <= '0;
      end
      if (issue) begin
         j_ff <= j_ff + CNT_BITS'(1);
      end
      // count the beat whose read data arrives in the cycle after its address
      if (cmd.sweep && pv_ff) begin
         lt_ff <= lt_ff + CNT_BITS'(rd_data < cand_ff);
         le_ff <= le_ff + CNT_BITS'(rd_data <= cand_ff);
      end
      if (cmd.eval) begin
         if (lt_ff <= k_lo && k_lo < le_ff) begin
            lo_ff <= cand_ff;
         end
         if (lt_ff <= k_hi && k_hi < le_ff) begin
            hi_ff <= cand_ff;
         end
         i_ff <= i_ff + CNT_BITS'(1);
      end
      if (cmd.load_out) begin
         med_ff <= MED_BITS'(lo_ff) + MED_BITS'(hi_ff);
         cnt_ff <= USED_BITS'(used_ff);
      end
   end

   assign sts.few_returns = (used_ff < MIN_USED);
   assign sts.sweep_done  = (j_ff == used_ff) && !pv_ff;
   assign sts.scan_last   = (i_ff == used_ff - CNT_BITS'(1));
   assign sts.out_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_median_x2  = med_ff;
   assign rsp_used_count = cnt_ff;
endmodule

[rtl/windowed_median_squared_return_core.sv]
// A bar with no result passes through the accept, square and check states; for a result
// over n returns, each return in turn is a rank candidate compared against all n.
// A new bar is taken only once the core is idle again (req_stall is high while busy);
// a stalled result delays the next result's load.
// Synchronous active-high reset clears the ring pointer, bar count, previous close,
// window (to 180) and output valid; ring contents stay undefined until written.
module windowed_median_squared_return_core
   import wmsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WIN_BITS-1:0]   csr_window_bars,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PRICE_BITS-1:0] req_close_price,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MED_BITS-1:0]   rsp_median_x2,
   output logic [USED_BITS-1:0]  rsp_used_count
);
   cmd_type cmd;
   sts_type sts;
   logic    idle;

   wmsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .idle      (idle),
      .sts       (sts),
      .cmd       (cmd)
   );

   wmsr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_valid       (csr_valid),
      .csr_window_bars (csr_window_bars),
      .req_close_price (req_close_price),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_median_x2   (rsp_median_x2),
      .rsp_used_count  (rsp_used_count)
   );

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
endmodule

[rtl/wmsr_checker.sv]
// Port-level assertions for the median core, bound to the top level.
module wmsr_checker
   import wmsr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [MED_BITS-1:0]   rsp_median_x2,
   input logic [USED_BITS-1:0]  rsp_used_count
);
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_used_count >= USED_BITS'(3)) &&
                    (rsp_used_count <= USED_BITS'(MAX_WINDOW)))
      else $error("used count out of range");

   a_odd_even: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_used_count[0]) |-> (rsp_median_x2[0] == 1'b0))
      else $error("odd count gave odd doubled median");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again without processing");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_median_x2)))
      else $error("stalled result changed");
endmodule

bind windowed_median_squared_return_core wmsr_checker u_wmsr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_median_x2  (rsp_median_x2),
   .rsp_used_count (rsp_used_count)
);
